// ===== hw/rtl/i2cts_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Shared item types, command and phase codes for the transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cts_pkg;

    localparam int BufDepth = 256;
    localparam int BufAddrW = 8;

    localparam logic [2:0] REQ_LOAD     = 3'd0;
    localparam logic [2:0] REQ_WRITE    = 3'd1;
    localparam logic [2:0] REQ_READ     = 3'd2;
    localparam logic [2:0] REQ_WR_RD    = 3'd3;
    localparam logic [2:0] REQ_EVENT    = 3'd4;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WT_IDLE   = 3'd1;
    localparam logic [2:0] PH_WR_ASET   = 3'd2;
    localparam logic [2:0] PH_WR_ACHK   = 3'd3;
    localparam logic [2:0] PH_WR_BYTE   = 3'd4;
    localparam logic [2:0] PH_RD_ASET   = 3'd5;
    localparam logic [2:0] PH_RD_ACHK   = 3'd6;
    localparam logic [2:0] PH_RD_BYTE   = 3'd7;

    localparam logic [2:0] RSP_DONE     = 3'd1;
    localparam logic [2:0] RSP_NAK      = 3'd2;
    localparam logic [2:0] RSP_ARB      = 3'd3;
    localparam logic [2:0] RSP_ERR      = 3'd4;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_RACK     = 3'd4;
    localparam logic [2:0] CMD_RNAK     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BUS_OCC   = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ARB      = 3'd1;
    localparam logic [2:0] ERR_CTRL     = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
    localparam logic [2:0] ERR_NO_SLAVE = 3'd4;
    localparam logic [2:0] ERR_SHORT    = 3'd5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [6:0] target_address;
        logic [8:0] transfer_length;
        logic [8:0] second_read_length;
        logic       bus_busy;
        logic [2:0] response_code;
        logic [7:0] data_byte;
        logic [7:0] load_index;
    } item_t;

    typedef struct packed {
        logic [1:0] start_status;
        logic [2:0] command;
        logic [7:0] command_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] read_index;
        logic [2:0] error_code;
        logic       busy_res;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [BufAddrW-1:0] addr;
        logic [7:0]          data;
    } buf_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Input beat register, sequencing core with write buffer, and result register.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless the output stalls; the core updates
// its state once per beat. Beats pass the input and then the result register.
// The write buffer read is registered and kept pointed at the next send byte.
// Reset clears the transfer state and both handshake stages; the write
// buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer
    import i2cts_pkg::*;
#(
    parameter int MAX_BYTES = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: target_address, transfer_length, second_read_length,
    // bus_busy, response_code, data_byte, load_index, zero fill.
    input  wire logic [47:0] s_tdata,
    // Fields from bit 0: req_type.
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: start_status, command, command_byte, read_valid,
    // read_byte, read_index, error_code, busy_res, zero fill.
    output logic      [39:0] m_tdata
);

    item_t               item_reg;
    logic                in_valid_reg;
    result_t             result_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                step;
    result_t             result;
    buf_wr_t             buf_wr;
    logic [BufAddrW-1:0] buf_rd_addr;
    logic [7:0]          buf_byte;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type           <= s_tuser;
            item_reg.target_address     <= s_tdata[6:0];
            item_reg.transfer_length    <= s_tdata[15:7];
            item_reg.second_read_length <= s_tdata[24:16];
            item_reg.bus_busy           <= s_tdata[25];
            item_reg.response_code      <= s_tdata[28:26];
            item_reg.data_byte          <= s_tdata[36:29];
            item_reg.load_index         <= s_tdata[44:37];
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    i2cts_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item_reg),
        .buf_byte    (buf_byte),
        .buf_wr      (buf_wr),
        .buf_rd_addr (buf_rd_addr),
        .result      (result)
    );

    i2cts_wbuf u_wbuf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_byte)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       result_reg.busy_res,
                       result_reg.error_code,
                       result_reg.read_index,
                       result_reg.read_byte,
                       result_reg.read_valid,
                       result_reg.command_byte,
                       result_reg.command,
                       result_reg.start_status};

endmodule

`default_nettype wire

// ===== hw/rtl/i2cts_wbuf.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer write buffer
// Single-port-write memory with a registered read that always holds the
// entry at the next send position, with write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cts_wbuf
    import i2cts_pkg::*;
(
    input  wire logic                clk,
    input  wire buf_wr_t             wr,
    input  wire logic [BufAddrW-1:0] rd_addr,
    output logic      [7:0]          rd_data
);

    logic [7:0] mem [BufDepth];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cts_core.sv =====
// ----------------------------------------------------------------------------
// I2C transfer sequencer core
// Transfer state registers and the per-beat update that decodes requests
// and completion events into byte commands, counts and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cts_core
    import i2cts_pkg::*;
#(
    parameter int MAX_BYTES = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire item_t               item,
    input  wire logic [7:0]          buf_byte,
    output buf_wr_t                  buf_wr,
    output logic      [BufAddrW-1:0] buf_rd_addr,
    output result_t                  result
);

    logic [2:0] phase_reg,       phase_next;
    logic [2:0] error_reg,       error_next;
    logic [6:0] address_reg,     address_next;
    logic [8:0] write_total_reg, write_total_next;
    logic [8:0] write_done_reg,  write_done_next;
    logic [8:0] read_total_reg,  read_total_next;
    logic [8:0] read_done_reg,   read_done_next;
    logic       then_read_reg,   then_read_next;

    logic       rsp_fail;
    logic       len_zero;
    logic       len2_zero;
    logic       len_big;
    logic       len2_big;
    logic [8:0] read_inc;
    logic [9:0] read_inc2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            error_reg       <= ERR_NONE;
            address_reg     <= '0;
            write_total_reg <= '0;
            write_done_reg  <= '0;
            read_total_reg  <= '0;
            read_done_reg   <= '0;
            then_read_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            error_reg       <= error_next;
            address_reg     <= address_next;
            write_total_reg <= write_total_next;
            write_done_reg  <= write_done_next;
            read_total_reg  <= read_total_next;
            read_done_reg   <= read_done_next;
            then_read_reg   <= then_read_next;
        end
    end

    assign rsp_fail  = !((item.response_code == RSP_DONE) || (item.response_code == RSP_NAK));
    assign len_zero  = (item.transfer_length == '0);
    assign len2_zero = (item.second_read_length == '0);
    assign len_big   = (32'(item.transfer_length) > 32'(MAX_BYTES));
    assign len2_big  = (32'(item.second_read_length) > 32'(MAX_BYTES));
    assign read_inc  = read_done_reg + 9'd1;
    assign read_inc2 = {1'b0, read_inc} + 10'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        error_next       = error_reg;
        address_next     = address_reg;
        write_total_next = write_total_reg;
        write_done_next  = write_done_reg;
        read_total_next  = read_total_reg;
        read_done_next   = read_done_reg;
        then_read_next   = then_read_reg;
        result           = '0;

        case (item.req_type)
            REQ_LOAD:
            begin
            end
            REQ_WRITE, REQ_READ, REQ_WR_RD:
            begin
                if ((item.req_type == REQ_WR_RD) ? (len_zero && len2_zero) : len_zero)
                begin
                    result.start_status = ST_OK;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    result.start_status = ST_BUSY;
                end
                else if (len_big || ((item.req_type == REQ_WR_RD) &&
                         (len_zero || len2_zero || len2_big)))
                begin
                    result.start_status = ST_BAD_LEN;
                end
                else
                begin
                    error_next       = ERR_NONE;
                    address_next     = item.target_address;
                    write_done_next  = '0;
                    read_done_next   = '0;
                    write_total_next = (item.req_type == REQ_READ) ? 9'd0 : item.transfer_length;
                    read_total_next  = (item.req_type == REQ_READ) ? item.transfer_length :
                                       (item.req_type == REQ_WR_RD) ? item.second_read_length :
                                       9'd0;
                    then_read_next   = (item.req_type == REQ_WR_RD);
                    if (item.bus_busy)
                    begin
                        phase_next          = PH_IDLE;
                        result.start_status = ST_BUS_OCC;
                    end
                    else
                    begin
                        phase_next     = (item.req_type == REQ_READ) ? PH_RD_ASET : PH_WR_ASET;
                        result.command = CMD_START;
                    end
                end
            end
            REQ_EVENT:
            begin
                if (phase_reg == PH_RD_BYTE)
                begin
                    result.read_valid = 1'b1;
                    result.read_byte  = item.data_byte;
                    result.read_index = read_done_reg[7:0];
                    read_done_next    = read_inc;
                    if (read_inc == read_total_reg)
                    begin
                        phase_next     = PH_WT_IDLE;
                        result.command = CMD_STOP;
                    end
                    else if (read_inc2 < {1'b0, read_total_reg})
                    begin
                        result.command = CMD_RACK;
                    end
                    else
                    begin
                        result.command = CMD_RNAK;
                    end
                end
                else if (rsp_fail)
                begin
                    if (item.response_code == RSP_ARB)
                    begin
                        error_next = ERR_ARB;
                        phase_next = PH_WT_IDLE;
                    end
                    else if (item.response_code == RSP_ERR)
                    begin
                        error_next = ERR_CTRL;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        error_next = ERR_UNKNOWN;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_WT_IDLE:
                        begin
                            if (!((write_done_reg == write_total_reg) &&
                                  (read_done_reg == read_total_reg)))
                            begin
                                error_next = ERR_SHORT;
                            end
                            phase_next = PH_IDLE;
                        end
                        PH_WR_ASET:
                        begin
                            result.command      = CMD_WRITE;
                            result.command_byte = {address_reg, 1'b0};
                            phase_next          = PH_WR_ACHK;
                        end
                        PH_WR_ACHK, PH_WR_BYTE:
                        begin
                            if (item.response_code == RSP_NAK)
                            begin
                                if (phase_reg == PH_WR_ACHK)
                                begin
                                    error_next = ERR_NO_SLAVE;
                                end
                                phase_next     = PH_WT_IDLE;
                                result.command = CMD_STOP;
                            end
                            else if (write_done_reg == write_total_reg)
                            begin
                                if (then_read_reg)
                                begin
                                    phase_next     = PH_RD_ASET;
                                    result.command = CMD_START;
                                end
                                else
                                begin
                                    phase_next     = PH_WT_IDLE;
                                    result.command = CMD_STOP;
                                end
                            end
                            else
                            begin
                                phase_next          = PH_WR_BYTE;
                                result.command      = CMD_WRITE;
                                result.command_byte = buf_byte;
                                write_done_next     = write_done_reg + 9'd1;
                            end
                        end
                        PH_RD_ASET:
                        begin
                            result.command      = CMD_WRITE;
                            result.command_byte = {address_reg, 1'b1};
                            phase_next          = PH_RD_ACHK;
                        end
                        PH_RD_ACHK:
                        begin
                            if (item.response_code == RSP_NAK)
                            begin
                                error_next     = ERR_NO_SLAVE;
                                phase_next     = PH_WT_IDLE;
                                result.command = CMD_STOP;
                            end
                            else
                            begin
                                phase_next     = PH_RD_BYTE;
                                result.command = (read_total_reg == 9'd1) ? CMD_RNAK : CMD_RACK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        result.error_code = error_next;
        result.busy_res   = (phase_next != PH_IDLE);
    end

    assign buf_wr.en     = step && (item.req_type == REQ_LOAD);
    assign buf_wr.addr   = item.load_index;
    assign buf_wr.data   = item.data_byte;
    assign buf_rd_addr   = step ? write_done_next[BufAddrW-1:0] : write_done_reg[BufAddrW-1:0];

endmodule

`default_nettype wire

// ===== tb/i2cts_seq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer result checker
// Watches both stream channels. Every accepted input beat is run through a
// local model of the sequencer, and every accepted output beat is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------

module i2cts_seq_checker
    import i2cts_pkg::*;
#(
    parameter int MaxBytes = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               mismatch_total,
    output int               results_pending
);

    logic [2:0] phase;
    logic [2:0] err_state;
    logic [6:0] dev_addr;
    logic [8:0] wr_total;
    logic [8:0] wr_done;
    logic [8:0] rd_total;
    logic [8:0] rd_done;
    logic       then_read;
    logic [7:0] wbuf [0:BufDepth-1];

    result_t predicted_results [$];

    function automatic bit response_aborts(input logic [2:0] rsp);
        if (rsp == RSP_DONE || rsp == RSP_NAK)
        begin
            return 1'b0;
        end
        if (rsp == RSP_ARB)
        begin
            err_state = ERR_ARB;
            phase     = PH_WT_IDLE;
        end
        else if (rsp == RSP_ERR)
        begin
            err_state = ERR_CTRL;
            phase     = PH_IDLE;
        end
        else
        begin
            err_state = ERR_UNKNOWN;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] arm_transfer(input logic [6:0] addr,
                                                input logic [8:0] wlen,
                                                input logic [8:0] rlen, input logic rd,
                                                input logic busy, input logic [2:0] first);
        err_state = ERR_NONE;
        dev_addr  = addr;
        wr_total  = wlen;
        wr_done   = '0;
        rd_total  = rlen;
        rd_done   = '0;
        then_read = rd;
        if (busy)
        begin
            phase = PH_IDLE;
            return ST_BUS_OCC;
        end
        phase = first;
        return ST_OK;
    endfunction

    function automatic result_t advance_sequencer(input logic [2:0] kind,
                                                  input logic [47:0] pay);
        logic [6:0] addr;
        logic [8:0] len;
        logic [8:0] len2;
        logic       busy;
        logic [2:0] rsp;
        logic [7:0] dbyte;
        logic [7:0] lidx;
        result_t    r;
        addr  = pay[6:0];
        len   = pay[15:7];
        len2  = pay[24:16];
        busy  = pay[25];
        rsp   = pay[28:26];
        dbyte = pay[36:29];
        lidx  = pay[44:37];
        r     = '0;
        case (kind)
            REQ_LOAD:
            begin
                wbuf[lidx] = dbyte;
            end
            REQ_WRITE, REQ_READ:
            begin
                if (len == 0)
                begin
                    r.start_status = ST_OK;
                end
                else if (phase != PH_IDLE)
                begin
                    r.start_status = ST_BUSY;
                end
                else if (len > MaxBytes)
                begin
                    r.start_status = ST_BAD_LEN;
                end
                else
                begin
                    if (kind == REQ_WRITE)
                    begin
                        r.start_status = arm_transfer(addr, len, '0, 1'b0, busy, PH_WR_ASET);
                    end
                    else
                    begin
                        r.start_status = arm_transfer(addr, '0, len, 1'b0, busy, PH_RD_ASET);
                    end
                    if (r.start_status == ST_OK)
                    begin
                        r.command = CMD_START;
                    end
                end
            end
            REQ_WR_RD:
            begin
                if (len == 0 && len2 == 0)
                begin
                    r.start_status = ST_OK;
                end
                else if (phase != PH_IDLE)
                begin
                    r.start_status = ST_BUSY;
                end
                else if (len == 0 || len2 == 0 || len > MaxBytes || len2 > MaxBytes)
                begin
                    r.start_status = ST_BAD_LEN;
                end
                else
                begin
                    r.start_status = arm_transfer(addr, len, len2, 1'b1, busy, PH_WR_ASET);
                    if (r.start_status == ST_OK)
                    begin
                        r.command = CMD_START;
                    end
                end
            end
            REQ_EVENT:
            begin
                case (phase)
                    PH_IDLE:
                    begin
                        void'(response_aborts(rsp));
                    end
                    PH_WT_IDLE:
                    begin
                        if (!response_aborts(rsp))
                        begin
                            if (!(wr_done == wr_total && rd_done == rd_total))
                            begin
                                err_state = ERR_SHORT;
                            end
                            phase = PH_IDLE;
                        end
                    end
                    PH_WR_ASET:
                    begin
                        if (!response_aborts(rsp))
                        begin
                            r.command      = CMD_WRITE;
                            r.command_byte = {dev_addr, 1'b0};
                            phase          = PH_WR_ACHK;
                        end
                    end
                    PH_WR_ACHK, PH_WR_BYTE:
                    begin
                        if (!response_aborts(rsp))
                        begin
                            if (rsp == RSP_NAK)
                            begin
                                if (phase == PH_WR_ACHK)
                                begin
                                    err_state = ERR_NO_SLAVE;
                                end
                                phase     = PH_WT_IDLE;
                                r.command = CMD_STOP;
                            end
                            else
                            begin
                                phase = PH_WR_BYTE;
                                if (wr_done == wr_total)
                                begin
                                    if (then_read)
                                    begin
                                        phase     = PH_RD_ASET;
                                        r.command = CMD_START;
                                    end
                                    else
                                    begin
                                        phase     = PH_WT_IDLE;
                                        r.command = CMD_STOP;
                                    end
                                end
                                else
                                begin
                                    r.command      = CMD_WRITE;
                                    r.command_byte = wbuf[wr_done[7:0]];
                                    wr_done        = wr_done + 1'b1;
                                end
                            end
                        end
                    end
                    PH_RD_ASET:
                    begin
                        if (!response_aborts(rsp))
                        begin
                            r.command      = CMD_WRITE;
                            r.command_byte = {dev_addr, 1'b1};
                            phase          = PH_RD_ACHK;
                        end
                    end
                    PH_RD_ACHK:
                    begin
                        if (!response_aborts(rsp))
                        begin
                            if (rsp == RSP_NAK)
                            begin
                                err_state = ERR_NO_SLAVE;
                                phase     = PH_WT_IDLE;
                                r.command = CMD_STOP;
                            end
                            else
                            begin
                                phase     = PH_RD_BYTE;
                                r.command = (rd_total == 1) ? CMD_RNAK : CMD_RACK;
                            end
                        end
                    end
                    default:
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte  = dbyte;
                        r.read_index = rd_done[7:0];
                        rd_done      = rd_done + 1'b1;
                        if (rd_done == rd_total)
                        begin
                            phase     = PH_WT_IDLE;
                            r.command = CMD_STOP;
                        end
                        else if (rd_done + 1 < rd_total)
                        begin
                            r.command = CMD_RACK;
                        end
                        else
                        begin
                            r.command = CMD_RNAK;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        r.error_code = err_state;
        r.busy_res   = (phase != PH_IDLE);
        return r;
    endfunction

    task automatic show_mismatch(input result_t want, input result_t got,
                                 input logic [5:0] pad);
        $display("%0t: expected st=%0d cmd=%0d cb=%h rv=%0d rb=%h ri=%0d err=%0d busy=%0d",
                 $realtime, want.start_status, want.command, want.command_byte,
                 want.read_valid, want.read_byte, want.read_index, want.error_code,
                 want.busy_res);
        $display("%0t: actual st=%0d cmd=%0d cb=%h rv=%0d rb=%h ri=%0d err=%0d busy=%0d pad=%h",
                 $realtime, got.start_status, got.command, got.command_byte,
                 got.read_valid, got.read_byte, got.read_index, got.error_code,
                 got.busy_res, pad);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            phase          = PH_IDLE;
            err_state      = ERR_NONE;
            dev_addr       = '0;
            wr_total       = '0;
            wr_done        = '0;
            rd_total       = '0;
            rd_done        = '0;
            then_read      = 1'b0;
            mismatch_total = 0;
            predicted_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_results.push_back(advance_sequencer(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.start_status = m_tdata[1:0];
                got.command      = m_tdata[4:2];
                got.command_byte = m_tdata[12:5];
                got.read_valid   = m_tdata[13];
                got.read_byte    = m_tdata[21:14];
                got.read_index   = m_tdata[29:22];
                got.error_code   = m_tdata[32:30];
                got.busy_res     = m_tdata[33];
                if (predicted_results.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                    begin
                        $display("%0t: result beat %h arrived with nothing predicted",
                                 $realtime, m_tdata);
                    end
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got !== want || m_tdata[39:34] !== 6'b0)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                        begin
                            show_mismatch(want, got, m_tdata[39:34]);
                        end
                    end
                end
            end
        end
        results_pending = predicted_results.size();
    end

endmodule

// ===== tb/tb_i2c_master_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives directed transfers and then randomized write, read and write-read
// sequences with random idling on both channels and one long output stall.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_i2c_master_transfer_sequencer;
    import i2cts_pkg::*;

    localparam int          RandomItems   = 2000;
    localparam int          HoldCycles    = 300;
    localparam int          WatchdogLimit = 5000;
    localparam int          DrainCycles   = 10;
    localparam logic [2:0]  RSP_PENDING   = 3'd0;
    localparam logic [2:0]  RSP_UNDEF_HI  = 3'd7;
    localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    int mismatch_total;
    int results_pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int item_count;
    int stall_cycles;
    bit hold_request;
    bit loaded [0:BufDepth-1];

    i2c_master_transfer_sequencer #(
        .MAX_BYTES(256)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    i2cts_seq_checker #(
        .MaxBytes(256)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_total  (mismatch_total),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit)
            begin
                $display("FAIL i2c_master_transfer_sequencer");
                $finish;
            end
        end
    end

    initial
    begin : rx_side
        int held;
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                for (held = 1; held < HoldCycles; held++)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [47:0] pack_fields(input logic [6:0] addr, input logic [8:0] len,
                                                input logic [8:0] len2, input logic busy,
                                                input logic [2:0] rsp, input logic [7:0] dbyte,
                                                input logic [7:0] lidx);
        return {3'b000, lidx, dbyte, rsp, busy, len2, len, addr};
    endfunction

    task automatic push_beat(input logic [2:0] kind, input logic [47:0] payload);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (kind == REQ_LOAD)
        begin
            loaded[payload[44:37]] = 1'b1;
        end
        if (kind <= REQ_EVENT)
        begin
            item_count++;
        end
    endtask

    // A write that can really run must only send buffer entries that were loaded.
    task automatic offer_item(input logic [2:0] kind, input logic [6:0] addr,
                              input logic [8:0] len, input logic [8:0] len2,
                              input logic busy, input logic [2:0] rsp,
                              input logic [7:0] dbyte, input logic [7:0] lidx);
        int need;
        int i;
        need = 0;
        if (!busy && (kind == REQ_WRITE || kind == REQ_WR_RD) && len <= 256)
        begin
            need = int'(len);
        end
        for (i = 0; i < need; i++)
        begin
            if (!loaded[i])
            begin
                push_beat(REQ_LOAD, pack_fields(7'($urandom_range(127)),
                                                9'($urandom_range(511)),
                                                9'($urandom_range(511)),
                                                1'($urandom_range(1)),
                                                3'($urandom_range(7)),
                                                8'($urandom_range(255)), 8'(i)));
            end
        end
        push_beat(kind, pack_fields(addr, len, len2, busy, rsp, dbyte, lidx));
    endtask

    task automatic offer_load(input logic [7:0] lidx, input logic [7:0] dbyte);
        offer_item(REQ_LOAD, 7'($urandom_range(127)), 9'($urandom_range(511)),
                   9'($urandom_range(511)), 1'($urandom_range(1)), 3'($urandom_range(7)),
                   dbyte, lidx);
    endtask

    task automatic offer_start(input logic [2:0] kind, input logic [6:0] addr,
                               input logic [8:0] len, input logic [8:0] len2,
                               input logic busy);
        offer_item(kind, addr, len, len2, busy, 3'($urandom_range(7)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic offer_event(input logic [2:0] rsp, input logic [7:0] dbyte);
        offer_item(REQ_EVENT, 7'($urandom_range(127)), 9'($urandom_range(511)),
                   9'($urandom_range(511)), 1'($urandom_range(1)), rsp, dbyte,
                   8'($urandom_range(255)));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(199);
        if (r == 0)
        begin
            return 256;
        end
        if (r == 1)
        begin
            return 0;
        end
        if (r < 24)
        begin
            return $urandom_range(40, 5);
        end
        return $urandom_range(4, 1);
    endfunction

    function automatic logic [2:0] pick_response();
        int r;
        r = $urandom_range(39);
        case (r)
            0:       return RSP_NAK;
            1:       return RSP_ARB;
            2:       return RSP_ERR;
            3:       return 3'($urandom_range(7));
            default: return RSP_DONE;
        endcase
    endfunction

    task automatic random_transfer();
        logic [2:0] kind;
        logic       busy;
        int         wlen;
        int         rlen;
        int         events;
        int         i;
        case ($urandom_range(2))
            0:       kind = REQ_WRITE;
            1:       kind = REQ_READ;
            default: kind = REQ_WR_RD;
        endcase
        wlen = pick_length();
        rlen = pick_length();
        busy = ($urandom_range(15) == 0);
        if (kind == REQ_WRITE)
        begin
            offer_start(kind, 7'($urandom_range(127)), 9'(wlen), 9'($urandom_range(511)),
                        busy);
            events = wlen + 3;
        end
        else if (kind == REQ_READ)
        begin
            offer_start(kind, 7'($urandom_range(127)), 9'(rlen), 9'($urandom_range(511)),
                        busy);
            events = rlen + 3;
        end
        else
        begin
            offer_start(kind, 7'($urandom_range(127)), 9'(wlen), 9'(rlen), busy);
            events = wlen + rlen + 5;
        end
        for (i = 0; i < events; i++)
        begin
            if ($urandom_range(24) == 0)
            begin
                offer_load(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            offer_event(pick_response(), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        int part;
        int goal;
        int pick;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        item_count   = 0;
        hold_request = 1'b0;
        for (pick = 0; pick < BufDepth; pick++)
        begin
            loaded[pick] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 76;
        offer_load(8'd0, 8'h00);
        offer_load(8'd1, 8'hFF);
        offer_load(8'd255, 8'h5A);
        offer_event(RSP_ARB, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_start(REQ_WRITE, 7'h00, 9'd0, 9'd0, 1'b0);
        offer_start(REQ_WRITE, 7'h00, 9'd511, 9'd0, 1'b0);
        offer_start(REQ_WR_RD, 7'h11, 9'd1, 9'd0, 1'b0);
        offer_start(REQ_WR_RD, 7'h7F, 9'd256, 9'd256, 1'b1);
        offer_start(REQ_WRITE, 7'h7F, 9'd2, 9'd0, 1'b0);
        offer_event(RSP_DONE, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_load(8'd1, 8'h81);
        offer_event(RSP_UNDEF_HI, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_start(REQ_READ, 7'h33, 9'd1, 9'd0, 1'b0);
        offer_event(RSP_DONE, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_start(REQ_READ, 7'h00, 9'd2, 9'd0, 1'b0);
        offer_event(RSP_DONE, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_event(RSP_ARB, 8'hFF);
        offer_event(RSP_PENDING, 8'h00);
        offer_event(RSP_DONE, 8'h00);
        offer_start(REQ_WR_RD, 7'h2A, 9'd1, 9'd1, 1'b0);
        offer_event(RSP_DONE, 8'h00);
        offer_event(RSP_NAK, 8'h00);
        offer_event(RSP_ERR, 8'h00);
        offer_item(REQ_UNUSED_HI, 7'h7F, 9'd511, 9'd511, 1'b1, RSP_UNDEF_HI, 8'hFF, 8'hFF);

        for (part = 0; part < 3; part++)
        begin
            case (part)
                0:
                begin
                    tx_idle_pct  = 10;
                    rx_idle_pct  = 76;
                    hold_request = 1'b1;
                end
                1:
                begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 10;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            goal = item_count + RandomItems / 3;
            while (item_count < goal)
            begin
                pick = $urandom_range(19);
                if (pick < 16)
                begin
                    random_transfer();
                end
                else if (pick < 18)
                begin
                    offer_load(8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                else
                begin
                    offer_item(3'($urandom_range(7)), 7'($urandom_range(127)),
                               9'($urandom_range(511)), 9'($urandom_range(511)),
                               1'($urandom_range(1)), 3'($urandom_range(7)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                end
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
        if (mismatch_total == 0)
        begin
            $display("PASS i2c_master_transfer_sequencer");
        end
        else
        begin
            $display("FAIL i2c_master_transfer_sequencer");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/i2cts_pkg.sv
hw/rtl/i2cts_wbuf.sv
hw/rtl/i2cts_core.sv
hw/rtl/i2c_master_transfer_sequencer.sv
tb/i2cts_seq_checker.sv
tb/tb_i2c_master_transfer_sequencer.sv
